### rtl/integer_to_ascii_formatter_top_macros.svh
// assertion macros for the integer to ascii formatter
`ifndef INTEGER_TO_ASCII_FORMATTER_TOP_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_TOP_MACROS_SVH

// same-cycle implication, checked at every clock edge out of reset
`define ITA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ita assertion failed");

// next-cycle implication
`define ITA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ita assertion failed");

`endif

### rtl/ita_pkg.sv
package ita_pkg;

	// format selector codes
	typedef enum logic [1:0] {
		ACT_UDEC  = 2'd0,
		ACT_SDEC  = 2'd1,
		ACT_HEX8  = 2'd2,
		ACT_HEX32 = 2'd3
	} ita_action_t;

	localparam int unsigned CMD_DEPTH_DEF = 2;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	// top digit index per format
	localparam logic [3:0] DEC_TOP_IDX   = 4'd9;
	localparam logic [3:0] HEX8_TOP_IDX  = 4'd1;
	localparam logic [3:0] HEX32_TOP_IDX = 4'd7;
	localparam int unsigned HEX8_ALIGN   = 24;
	localparam int unsigned NIB_W        = 4;

	// classified request handed from front to back
	typedef struct packed {
		logic        is_hex;
		logic        neg;
		logic [3:0]  idx;
		logic [31:0] data;
	} ita_cmd_t;

	// back end status seen by the top level
	typedef struct packed {
		logic busy;
		logic load;
	} ita_back_stat_t;

	function automatic logic [33:0] pow10(input logic [3:0] k);
		logic [33:0] p;
		unique case (k)
			4'd0: p = 34'd1;
			4'd1: p = 34'd10;
			4'd2: p = 34'd100;
			4'd3: p = 34'd1000;
			4'd4: p = 34'd10000;
			4'd5: p = 34'd100000;
			4'd6: p = 34'd1000000;
			4'd7: p = 34'd10000000;
			4'd8: p = 34'd100000000;
			4'd9: p = 34'd1000000000;
			default: p = '0;
		endcase
		return p;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] c;
		if (nib < 4'd10) begin
			c = CH_ZERO + {4'b0, nib};
		end else begin
			c = CH_UPPER_A + {4'b0, nib - 4'd10};
		end
		return c;
	endfunction

endpackage

### rtl/integer_to_ascii_formatter_top.sv
// integer to ascii formatter
// input queue side: drive action and value with push; a request is taken at a
// clock edge where push is high and full is low. action 0 prints unsigned
// decimal, 1 signed decimal, 2 the low byte as two hex digits, 3 the whole
// word as eight hex digits (uppercase, leading zeros kept).
// result queue side: while empty is low, character holds the oldest waiting
// ascii code and last marks the final character of a request; pop with empty
// low takes it. characters come most significant first.
// with the back end free, a request is loaded first and its first character is
// then registered for hex or a minus sign; decimal first walks the suppressed
// leading zeros, one step each, and emits nothing for them.
// the back end loads a request, then takes one step per decimal digit position
// (ten, suppressed leading zeros included), one more for a minus sign, or one
// per hex digit: two for a hex byte, eight for a hex word. each step waits while
// the output register holds a character that is not popped. a short request
// queue lets requests arrive while the back end works.
// a stalled receiver holds the output register; the back end then waits and
// the request queue fills until full rises. reset empties both queues.
`include "integer_to_ascii_formatter_top_macros.svh"

module integer_to_ascii_formatter_top #(
	parameter int unsigned CMD_DEPTH = ita_pkg::CMD_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  action,
	input  logic [31:0] value,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  character,
	output logic        last
);
	import ita_pkg::*;

	ita_cmd_t       front_cmd;
	ita_cmd_t       head_cmd;
	logic           cmd_empty;
	logic           cmd_pop;
	ita_back_stat_t back_stat;

	// classify the request: magnitude, sign, hex alignment and digit count
	ita_front u_front (
		.action (action),
		.value  (value),
		.cmd    (front_cmd)
	);

	// decouples request intake from character emission
	ita_cmd_fifo #(
		.DEPTH (CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (front_cmd),
		.full   (full),
		.pop    (cmd_pop),
		.rd_cmd (head_cmd),
		.empty  (cmd_empty)
	);

	// digit sequencer and output register
	ita_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (head_cmd),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.stat      (back_stat),
		.character (character),
		.last      (last),
		.empty     (empty),
		.pop       (pop)
	);

	// a minus sign is never the final character
	`ITA_ASSERT_IMP(a_minus_not_last, clk, arst_n, !empty && character == CH_MINUS, !last)

	// an idle back end with a waiting request picks it up at once
	`ITA_ASSERT_NXT(a_load_starts, clk, arst_n, !cmd_empty && !back_stat.busy, back_stat.busy)

	// only digits, uppercase hex letters and minus reach the output
	`ITA_ASSERT_IMP(a_char_legal, clk, arst_n, !empty,
		(character >= 8'h30 && character <= 8'h39) ||
		(character >= 8'h41 && character <= 8'h46) || character == CH_MINUS)

endmodule

### rtl/ita_front.sv
module ita_front (
	input  logic [1:0]       action,
	input  logic [31:0]      value,
	output ita_pkg::ita_cmd_t cmd
);
	import ita_pkg::*;

	ita_action_t act;

	assign act = ita_action_t'(action);

	always_comb begin
		cmd = '0;
		unique case (act)
			ACT_UDEC: begin
				cmd.is_hex = 1'b0;
				cmd.neg    = 1'b0;
				cmd.idx    = DEC_TOP_IDX;
				cmd.data   = value;
			end
			ACT_SDEC: begin
				// magnitude modulo 2^32, so the most negative value maps to itself
				cmd.is_hex = 1'b0;
				cmd.neg    = value[31];
				cmd.idx    = DEC_TOP_IDX;
				cmd.data   = value[31] ? (~value + 32'd1) : value;
			end
			ACT_HEX8: begin
				// low byte moved to the top so the back always takes the top nibble
				cmd.is_hex = 1'b1;
				cmd.neg    = 1'b0;
				cmd.idx    = HEX8_TOP_IDX;
				cmd.data   = value << HEX8_ALIGN;
			end
			ACT_HEX32: begin
				cmd.is_hex = 1'b1;
				cmd.neg    = 1'b0;
				cmd.idx    = HEX32_TOP_IDX;
				cmd.data   = value;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

### rtl/ita_cmd_fifo.sv
module ita_cmd_fifo #(
	parameter int unsigned DEPTH = ita_pkg::CMD_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ita_pkg::ita_cmd_t wr_cmd,
	output logic              full,
	input  logic              pop,
	output ita_pkg::ita_cmd_t rd_cmd,
	output logic              empty
);
	import ita_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	ita_cmd_t        mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rd_cmd  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule

### rtl/ita_back.sv
module ita_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ita_pkg::ita_cmd_t       cmd,
	input  logic                    cmd_empty,
	output logic                    cmd_pop,
	output ita_pkg::ita_back_stat_t stat,
	output logic [7:0]              character,
	output logic                    last,
	output logic                    empty,
	input  logic                    pop
);
	import ita_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SIGN = 4'b0010,
		ST_DEC  = 4'b0100,
		ST_HEX  = 4'b1000
	} ita_state_t;

	ita_state_t  state_q, state_d;
	logic [31:0] data_q, data_d;
	logic [3:0]  idx_q, idx_d;
	logic        started_q, started_d;
	logic        out_valid_q, out_valid_d;
	logic [7:0]  out_char_q;
	logic        out_last_q;

	logic        room;
	logic        emit;
	logic [7:0]  emit_char;
	logic        emit_last;
	logic        load;

	logic [33:0] pw;
	logic [33:0] thr;
	logic [33:0] sub;
	logic [3:0]  dig;
	logic        show;

	assign room  = ~out_valid_q | pop;
	assign load  = (state_q == ST_IDLE) & ~cmd_empty;
	assign cmd_pop = load;
	assign stat.busy = (state_q != ST_IDLE);
	assign stat.load = load;

	assign character = out_char_q;
	assign last      = out_last_q;
	assign empty     = ~out_valid_q;

	// one decimal digit per step: compare against the nine multiples of 10^idx
	always_comb begin
		pw  = pow10(idx_q);
		dig = '0;
		sub = '0;
		thr = '0;
		for (int d = 1; d <= 9; d++) begin
			thr = 34'(d) * pw;
			if ({2'b00, data_q} >= thr) begin
				dig = 4'(d);
				sub = thr;
			end
		end
		show = started_q | (dig != 4'd0) | (idx_q == 4'd0);
	end

	always_comb begin
		state_d   = state_q;
		data_d    = data_q;
		idx_d     = idx_q;
		started_d = started_q;
		emit      = 1'b0;
		emit_char = CH_ZERO;
		emit_last = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (load) begin
					data_d    = cmd.data;
					idx_d     = cmd.idx;
					started_d = 1'b0;
					if (cmd.is_hex) begin
						state_d = ST_HEX;
					end else if (cmd.neg) begin
						state_d = ST_SIGN;
					end else begin
						state_d = ST_DEC;
					end
				end
			end
			ST_SIGN: begin
				if (room) begin
					emit      = 1'b1;
					emit_char = CH_MINUS;
					state_d   = ST_DEC;
				end
			end
			ST_DEC: begin
				if (room) begin
					emit      = show;
					emit_char = CH_ZERO + {4'b0, dig};
					emit_last = (idx_q == 4'd0);
					started_d = show;
					data_d    = data_q - sub[31:0];
					if (idx_q == 4'd0) begin
						state_d = ST_IDLE;
					end else begin
						idx_d = idx_q - 4'd1;
					end
				end
			end
			ST_HEX: begin
				if (room) begin
					emit      = 1'b1;
					emit_char = hex_char(data_q[31 -: NIB_W]);
					emit_last = (idx_q == 4'd0);
					data_d    = data_q << NIB_W;
					if (idx_q == 4'd0) begin
						state_d = ST_IDLE;
					end else begin
						idx_d = idx_q - 4'd1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		out_valid_d = emit ? 1'b1 : (pop ? 1'b0 : out_valid_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			started_q   <= started_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
		idx_q  <= idx_d;
		if (emit) begin
			out_char_q <= emit_char;
			out_last_q <= emit_last;
		end
	end

endmodule

### sim/testbench.sv
module testbench;
	import ita_pkg::*;

	// no request or character accepted for this many cycles ends the run
	localparam int unsigned STALL_LIMIT = 4000;
	// cycles allowed after the last character for stray output to show
	localparam int unsigned TAIL_CYCLES = 40;
	// result count at which the receiver holds off for a long stretch
	localparam int unsigned HOLD_AT_CHAR = 180;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned RANDOM_REQS  = 90;

	localparam logic [7:0] GLYPH_MINUS = "-";
	localparam string HEX_GLYPHS = "0123456789ABCDEF";

	// one formatting request waiting to be driven
	typedef struct {
		ita_action_t act;
		logic [31:0] val;
		bit          drain;
	} format_request_t;

	// one expected output character
	typedef struct {
		logic [7:0] character;
		logic       last;
	} ascii_char_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	ita_action_t action = ACT_UDEC;
	logic [31:0] value = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [7:0]  character;
	logic        last;

	format_request_t pending_requests[$];
	ascii_char_t     expected_chars[$];
	int unsigned     mismatch_count = 0;
	int unsigned     chars_seen = 0;
	int unsigned     idle_cycles = 0;

	integer_to_ascii_formatter_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.action    (action),
		.value     (value),
		.empty     (empty),
		.pop       (pop),
		.character (character),
		.last      (last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch: %s", msg);
		mismatch_count++;
	endtask

	// works out the text of one request and queues its characters
	function automatic void predict_text(input ita_action_t act, input logic [31:0] val);
		logic [7:0]  text[$];
		logic [31:0] mag;
		logic [3:0]  nib;
		int          nibbles;
		text = {};
		case (act)
			ACT_UDEC, ACT_SDEC: begin
				mag = val;
				// signed mode: minus, then the magnitude modulo 2^32
				if (act == ACT_SDEC && val[31]) begin
					text.push_back(GLYPH_MINUS);
					mag = ~val + 32'd1;
				end
				if (mag == 32'd0) begin
					text.push_back(HEX_GLYPHS[0]);
				end else begin
					// digits come least significant first, so insert after the sign
					nibbles = text.size();
					while (mag != 32'd0) begin
						text.insert(nibbles, HEX_GLYPHS[mag % 32'd10]);
						mag = mag / 32'd10;
					end
				end
			end
			default: begin
				// hex keeps leading zeros, byte mode looks at the low byte only
				nibbles = (act == ACT_HEX8) ? 2 : 8;
				for (int i = nibbles - 1; i >= 0; i--) begin
					nib = val[4 * i +: 4];
					text.push_back(HEX_GLYPHS[nib]);
				end
			end
		endcase
		foreach (text[i]) begin
			expected_chars.push_back('{text[i], (i == text.size() - 1)});
		end
	endfunction

	// sender: offers queued requests, random gaps between them
	int unsigned sender_gap = 0;
	bit          sender_lazy = 1'b0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			sender_gap = 0;
		end else begin : drive_requests
			logic            offering;
			format_request_t req;
			offering = push;
			if (push && !full) begin
				predict_text(action, value);
				offering = 1'b0;
				// switch between stretches with and without gaps now and then
				if ($urandom_range(0, 11) == 0) begin
					sender_lazy = ~sender_lazy;
				end
				sender_gap = sender_lazy ? $urandom_range(0, 9) : 0;
			end
			if (!offering) begin
				if (sender_gap > 0) begin
					sender_gap--;
				end else if (pending_requests.size() > 0) begin
					// a drain request waits until every character has come back
					if (!pending_requests[0].drain || expected_chars.size() == 0) begin
						req = pending_requests.pop_front();
						action <= req.act;
						value <= req.val;
						offering = 1'b1;
					end
				end
			end
			push <= offering;
		end
	end

	// receiver: checks each popped character, random stalls plus one long hold
	int unsigned receiver_stall = 0;
	bit          receiver_lazy = 1'b0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			receiver_stall = 0;
		end else begin : check_chars
			logic        ready;
			ascii_char_t want;
			ready = pop;
			if (pop && !empty) begin
				chars_seen++;
				if (expected_chars.size() == 0) begin
					report_mismatch($sformatf("unexpected character 0x%02h last %0b",
						character, last));
				end else begin
					want = expected_chars.pop_front();
					if (character !== want.character) begin
						report_mismatch($sformatf("character %0d: got 0x%02h, want 0x%02h",
							chars_seen, character, want.character));
					end
					if (last !== want.last) begin
						report_mismatch($sformatf("character %0d: last got %0b, want %0b",
							chars_seen, last, want.last));
					end
				end
				if ($urandom_range(0, 15) == 0) begin
					receiver_lazy = ~receiver_lazy;
				end
				receiver_stall = receiver_lazy ? $urandom_range(0, 9) : 0;
				// long hold so the request queue fills and full rises
				if (chars_seen == HOLD_AT_CHAR) begin
					receiver_stall = HOLD_CYCLES;
				end
				ready = (receiver_stall == 0);
			end else if (!pop) begin
				if (receiver_stall > 0) begin
					receiver_stall--;
				end
				ready = (receiver_stall == 0);
			end
			pop <= ready;
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout after %0d idle cycles", idle_cycles);
				$display("*** FAILED ***");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	function automatic void queue_request(input ita_action_t act, input logic [31:0] val,
		input bit drain);
		pending_requests.push_back('{act, val, drain});
	endfunction

	initial begin : stimulus
		ita_action_t act;
		logic [31:0] val;
		int unsigned shape;

		// directed: zero in both decimal modes, no leading zeros, widest values
		queue_request(ACT_UDEC, 32'd0, 1'b0);
		queue_request(ACT_UDEC, 32'd1, 1'b0);
		queue_request(ACT_UDEC, 32'd9, 1'b0);
		queue_request(ACT_UDEC, 32'd10, 1'b0);
		queue_request(ACT_UDEC, 32'd1000000000, 1'b0);
		queue_request(ACT_UDEC, 32'hFFFF_FFFF, 1'b0);
		queue_request(ACT_SDEC, 32'd0, 1'b0);
		queue_request(ACT_SDEC, 32'd5, 1'b0);
		// most negative value, largest positive, minus one, minus ten
		queue_request(ACT_SDEC, 32'h8000_0000, 1'b0);
		queue_request(ACT_SDEC, 32'h7FFF_FFFF, 1'b0);
		queue_request(ACT_SDEC, 32'hFFFF_FFFF, 1'b0);
		queue_request(ACT_SDEC, 32'hFFFF_FFF6, 1'b0);
		// hex byte: padding, uppercase, upper bits ignored
		queue_request(ACT_HEX8, 32'h0000_0000, 1'b0);
		queue_request(ACT_HEX8, 32'h0000_00FF, 1'b0);
		queue_request(ACT_HEX8, 32'hFFFF_FF5A, 1'b0);
		queue_request(ACT_HEX8, 32'h1234_5607, 1'b0);
		// hex word: leading zeros kept, every letter glyph
		queue_request(ACT_HEX32, 32'h0000_0000, 1'b0);
		queue_request(ACT_HEX32, 32'hFFFF_FFFF, 1'b0);
		queue_request(ACT_HEX32, 32'h0123_ABCD, 1'b0);
		queue_request(ACT_HEX32, 32'h89AB_CDEF, 1'b0);

		// random: a mix of short and full-width values in all formats
		for (int n = 0; n < RANDOM_REQS; n++) begin
			act = ita_action_t'($urandom_range(0, 3));
			shape = $urandom_range(0, 3);
			case (shape)
				0: val = $urandom >> $urandom_range(0, 31);
				1: val = -($urandom >> $urandom_range(0, 31));
				default: val = $urandom;
			endcase
			// first random request and one later one wait for a full drain
			queue_request(act, val, (n == 0) || (n == 70));
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_requests.size() != 0 || push || expected_chars.size() != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
